/* hw/rtl/lfvs_pkg.sv */
`default_nettype none

package lfvs_pkg;

	localparam int MASK_BITS = 16;
	localparam int FRAME_BITS = 4;

	localparam logic CMD_PIN = 1'b0;
	localparam logic CMD_VICTIM = 1'b1;

	typedef struct packed {
		logic command;
		logic [FRAME_BITS-1:0] frame;
		logic [MASK_BITS-1:0] pinned_mask;
	} cmd_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] victim_frame;
		logic no_free_frame;
	} res_t;

endpackage

`default_nettype wire

/* hw/rtl/lfu_frame_victim_select_top.sv */
`default_nettype none

// Channel | Direction | Payload | Handshake
// cmd     | in        | cmd_t   | cmd_valid / cmd_stall
// res     | out       | res_t   | res_valid / res_stall
//
// A pin transaction does one counter read and one write on the counter RAM.
// In a victim transaction the RAM read port delivers one counter a cycle to a single
// compare unit, then the result is loaded into the output register.
// Reset clears every per-frame valid bit at once, so all counters read as zero after it.
// A victim result waits in its register while res_stall is high; further pin
// transactions are taken meanwhile, a further victim result waits for the register.

module lfu_frame_victim_select_top
	import lfvs_pkg::*;
#(
	parameter int FRAMES = 16,
	parameter int COUNT_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output      logic cmd_stall,
	input  wire cmd_t cmd_data,
	output      logic res_valid,
	input  wire logic res_stall,
	output      res_t res_data
);

	localparam int IDX_W = $clog2(FRAMES);
	localparam int EXT_W = ((IDX_W > FRAME_BITS) ? IDX_W : FRAME_BITS) + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIN_WR,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [FRAMES-1:0]     valid_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic [IDX_W-1:0]      pin_idx_q;
	logic [IDX_W-1:0]      best_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic                  found_q;
	logic [MASK_BITS-1:0]  mask_q;
	logic                  res_valid_q;
	res_t                  res_data_q;

	logic                  cmd_acc;
	logic                  in_range;
	logic [IDX_W-1:0]      rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  ram_we;
	logic [EXT_W-1:0]      cmp_ext;
	logic [EXT_W-1:0]      best_ext;
	logic                  pinned;
	logic                  take;
	logic                  cmp_last;
	logic                  res_free;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign in_range = ({{(32 - FRAME_BITS){1'b0}}, cmd_data.frame} < 32'(FRAMES));
	assign cmp_last = (cmp_idx_q == LAST_IDX);
	assign res_free = !res_valid_q || !res_stall;

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_data.command == CMD_PIN && in_range) begin
					rd_addr = IDX_W'(cmd_data.frame);
				end
			end
			ST_SCAN: begin
				if (!cmp_last) begin
					rd_addr = cmp_idx_q + 1'b1;
				end
			end
			default: rd_addr = '0;
		endcase
	end

	assign cnt = rd_vld_s1 ? rd_data : '0;
	assign cnt_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + 1'b1;
	assign ram_we = (state_q == ST_PIN_WR);

	assign cmp_ext = EXT_W'(cmp_idx_q);
	assign best_ext = EXT_W'(best_q);
	assign pinned = (cmp_ext < EXT_W'(MASK_BITS)) && mask_q[cmp_ext[FRAME_BITS-1:0]];
	assign take = !pinned && (!found_q || cnt < best_cnt_q);

	lfvs_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(FRAMES)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pin_idx_q),
		.wdata(cnt_inc),
		.re   (1'b1),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			rd_vld_s1 <= 1'b0;
			cmp_idx_q <= '0;
			pin_idx_q <= '0;
			best_q <= '0;
			best_cnt_q <= '0;
			found_q <= 1'b0;
			mask_q <= '0;
			res_valid_q <= 1'b0;
			res_data_q <= '0;
		end else begin
			rd_vld_s1 <= valid_q[rd_addr];
			if (state_q == ST_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd_data.command == CMD_VICTIM) begin
							cmp_idx_q <= '0;
							found_q <= 1'b0;
							mask_q <= cmd_data.pinned_mask;
							state_q <= ST_SCAN;
						end else if (in_range) begin
							pin_idx_q <= IDX_W'(cmd_data.frame);
							state_q <= ST_PIN_WR;
						end
					end
				end
				ST_PIN_WR: begin
					valid_q[pin_idx_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
						best_q <= cmp_idx_q;
						best_cnt_q <= cnt;
					end
					if (cmp_last) begin
						state_q <= ST_DONE;
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						res_data_q.no_free_frame <= !found_q;
						res_data_q.victim_frame <= found_q ? best_ext[FRAME_BITS-1:0] : '0;
						if (found_q) begin
							valid_q[best_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_data_q;

	a_pin_goes_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd_data.command == CMD_PIN && in_range |=> state_q == ST_PIN_WR)
		else $error("pin transaction did not reach the counter write");

	a_victim_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_free && found_q |=> !valid_q[$past(best_q)])
		else $error("chosen victim counter was not cleared");

	a_no_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.no_free_frame |-> res_data.victim_frame == '0)
		else $error("victim index not zero when no frame is free");

	a_scan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && !cmp_last |=> state_q == ST_SCAN && cmd_stall)
		else $error("scan left early or took a transaction");

endmodule

`default_nettype wire

/* hw/rtl/lfvs_ram.sv */
`default_nettype none

module lfvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* dv/lfu_frame_victim_select_top_tb.sv */
`timescale 1ns / 1ps

module lfu_frame_victim_select_top_tb
	import lfvs_pkg::*;
();

	localparam int FRAMES = 16;
	localparam int COUNT_W = 32;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	logic [COUNT_W-1:0] use_count [FRAMES];
	res_t victim_q [$];
	int errors = 0;
	int cycles = 0;
	int send_gap_max = 10;
	int stall_gap_max = 10;

	lfu_frame_victim_select_top #(
		.FRAMES(FRAMES),
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lfu_frame_victim_select_top: mismatch");
			$finish;
		end
	end

	function automatic cmd_t pin_cmd(input logic [FRAME_BITS-1:0] f);
		cmd_t c;
		c.command = CMD_PIN;
		c.frame = f;
		c.pinned_mask = MASK_BITS'($urandom);
		return c;
	endfunction

	function automatic cmd_t victim_cmd(input logic [MASK_BITS-1:0] m);
		cmd_t c;
		c.command = CMD_VICTIM;
		c.frame = FRAME_BITS'($urandom);
		c.pinned_mask = m;
		return c;
	endfunction

	function automatic logic [MASK_BITS-1:0] random_mask();
		logic [MASK_BITS-1:0] m;
		case ($urandom_range(0, 5))
			0: m = MASK_BITS'($urandom);
			1: m = '1;
			2: m = '0;
			3: m = MASK_BITS'($urandom & $urandom & $urandom);
			4: m = MASK_BITS'($urandom | $urandom | $urandom);
			default: m = ~(16'h1 << $urandom_range(0, MASK_BITS - 1));
		endcase
		return m;
	endfunction

	// Applies one accepted command to the counter copy and queues the victim it yields.
	function automatic void update_use_counts(input cmd_t c);
		logic [COUNT_W-1:0] best_count;
		int best;
		bit found;
		res_t r;
		if (c.command == CMD_PIN) begin
			if (c.frame < FRAMES && use_count[c.frame] != '1)
				use_count[c.frame] = use_count[c.frame] + 1'b1;
		end else begin
			found = 1'b0;
			best = 0;
			best_count = '0;
			for (int i = 0; i < FRAMES; i++) begin
				if (i < MASK_BITS && c.pinned_mask[i])
					continue;
				if (!found || use_count[i] < best_count) begin
					found = 1'b1;
					best = i;
					best_count = use_count[i];
				end
			end
			r.no_free_frame = !found;
			r.victim_frame = found ? FRAME_BITS'(best) : '0;
			if (found)
				use_count[best] = '0;
			victim_q.push_back(r);
		end
	endfunction

	task automatic issue_command(input cmd_t c);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= c;
		do @(posedge clk); while (cmd_stall);
		update_use_counts(c);
	endtask

	task automatic wait_drained();
		while (victim_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic pause_until_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		wait_drained();
	endtask

	task automatic test_reset_state();
		issue_command(victim_cmd(16'h0000));
		issue_command(victim_cmd(16'hFFFF));
	endtask

	task automatic test_field_extremes();
		issue_command(pin_cmd(4'd0));
		issue_command(pin_cmd(4'd15));
		issue_command(victim_cmd(16'hFFFE));
		issue_command(victim_cmd(16'h7FFF));
		issue_command(victim_cmd(16'h0000));
	endtask

	task automatic test_heavy_use();
		repeat (20)
			issue_command(pin_cmd(4'd9));
		pause_until_drained();
		issue_command(victim_cmd(~(16'h1 << 9)));
	endtask

	task automatic test_random_traffic(input int n);
		logic [FRAME_BITS-1:0] hot;
		hot = FRAME_BITS'($urandom);
		repeat (n) begin
			if ($urandom_range(0, 99) < 65) begin
				if ($urandom_range(0, 3) == 0)
					issue_command(pin_cmd(hot));
				else
					issue_command(pin_cmd(FRAME_BITS'($urandom)));
			end else begin
				issue_command(victim_cmd(random_mask()));
			end
		end
	endtask

	initial begin : result_sink
		int hold;
		res_t exp;
		hold = 0;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (victim_q.size() == 0) begin
					$error("unexpected transaction: victim_frame=%0d no_free_frame=%0d",
						res_data.victim_frame, res_data.no_free_frame);
					errors++;
				end else begin
					exp = victim_q.pop_front();
					if (res_data.victim_frame !== exp.victim_frame) begin
						$error("victim_frame: expected %0d, actual %0d",
							exp.victim_frame, res_data.victim_frame);
						errors++;
					end
					if (res_data.no_free_frame !== exp.no_free_frame) begin
						$error("no_free_frame: expected %0d, actual %0d",
							exp.no_free_frame, res_data.no_free_frame);
						errors++;
					end
				end
				hold = $urandom_range(0, stall_gap_max);
				if (hold > 0)
					res_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				if (hold == 0)
					res_stall <= 1'b0;
			end
		end
	end

	initial begin
		cmd_valid = 1'b0;
		cmd_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < FRAMES; i++)
			use_count[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_heavy_use();

		test_random_traffic(700);
		pause_until_drained();
		send_gap_max = 0;
		stall_gap_max = 0;
		test_random_traffic(450);
		send_gap_max = 10;
		test_random_traffic(350);
		send_gap_max = 0;
		stall_gap_max = 10;
		test_random_traffic(350);

		cmd_valid <= 1'b0;
		wait_drained();
		repeat (2 * FRAMES + 8) @(posedge clk);
		if (errors == 0)
			$display("lfu_frame_victim_select_top: match");
		else
			$display("lfu_frame_victim_select_top: mismatch");
		$finish;
	end

endmodule
